// ===== rtl/core/section_timing_statistics_unit_defines.svh =====
// Assertion macros shared by the section timing statistics checker.
`ifndef SECTION_TIMING_STATISTICS_UNIT_DEFINES_SVH
`define SECTION_TIMING_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("section timing statistics check failed");

// Next-cycle implication.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("section timing statistics check failed");

`endif

// ===== rtl/core/sts_pkg.sv =====
// Types and constants of the section timing statistics unit.
`default_nettype none

package sts_pkg;

    localparam int OP_W      = 3;
    localparam int SLOT_W    = 5;
    localparam int TIME_W    = 32;
    localparam int SIDX_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_BEGIN = 3'd0;
    localparam logic [OP_W-1:0] OP_END   = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD  = 1'd1;

    localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_time;
        logic [SIDX_W-1:0] sample_index;
    } in_item_t;

    typedef struct packed {
        logic               slot_used;
        logic [TIME_W-1:0]  elapsed_time;
        logic [TIME_W-1:0]  total_time;
        logic [TIME_W-1:0]  call_count;
        logic [TIME_W-1:0]  min_time;
        logic [TIME_W-1:0]  max_time;
        logic [COUNT_W-1:0] sample_count;
        logic [TIME_W-1:0]  sample_value;
        logic [COUNT_W-1:0] longest_run;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sts_ctrl.sv =====
// Controller of the section timing statistics unit: item sequencing and output handshake.
`default_nettype none

module sts_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    output sts_pkg::cmd_t     cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sts_datapath.sv =====
// Datapath of the section timing statistics unit: slot records, sample store, result register.
`default_nettype none

module sts_datapath #(
    parameter int SLOTS            = 32,
    parameter int SAMPLES_PER_SLOT = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sts_pkg::cmd_t                   cmd,
    input  wire sts_pkg::in_item_t               in_item,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [sts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic                            cfg_data,
    output sts_pkg::out_item_t                   out_item
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SAMPLES_PER_SLOT + 1);
    localparam int DEPTH = SLOTS * SAMPLES_PER_SLOT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = sts_pkg::TIME_W;
    localparam int OW    = sts_pkg::COUNT_W;

    logic              enabled_reg;
    logic              record_reg;

    logic [TW-1:0]     start_reg [SLOTS];
    logic              used_reg  [SLOTS];
    logic [TW-1:0]     sum_reg   [SLOTS];
    logic [TW-1:0]     min_reg   [SLOTS];
    logic [TW-1:0]     max_reg   [SLOTS];
    logic [TW-1:0]     calls_reg [SLOTS];
    logic [CW-1:0]     cnt_reg   [SLOTS];
    logic [CW-1:0]     peak_reg;

    logic [TW-1:0]     mem [DEPTH];
    logic [TW-1:0]     rd_data_reg;

    sts_pkg::in_item_t  item_reg;
    sts_pkg::out_item_t out_item_reg;
    sts_pkg::out_item_t out_item_next;

    logic [SW+4:0]     slot_wide;
    logic [SW-1:0]     idx;
    logic              slot_ok;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;

    logic [TW-1:0]     cur_start;
    logic              cur_used;
    logic [TW-1:0]     cur_sum;
    logic [TW-1:0]     cur_min;
    logic [TW-1:0]     cur_max;
    logic [TW-1:0]     cur_calls;
    logic [CW-1:0]     cur_cnt;
    logic [TW-1:0]     elapsed;

    logic              do_begin;
    logic              do_end;
    logic              do_clear;
    logic              do_log;
    logic              read_hit;
    logic [CW-1:0]     cnt_after;

    logic [TW-1:0]     start_next;
    logic              used_next;
    logic [TW-1:0]     sum_next;
    logic [TW-1:0]     min_next;
    logic [TW-1:0]     max_next;
    logic [TW-1:0]     calls_next;
    logic [CW-1:0]     cnt_next;
    logic [CW-1:0]     peak_next;
    logic [CW+OW-1:0]  cnt_wide;
    logic [CW+OW-1:0]  peak_wide;

    // slot decode
    assign slot_wide = {{SW{1'b0}}, item_reg.slot};
    assign idx       = slot_wide[SW-1:0];
    assign slot_ok   = (32'(item_reg.slot) < SLOTS);

    assign cur_start = start_reg[idx];
    assign cur_used  = used_reg[idx];
    assign cur_sum   = sum_reg[idx];
    assign cur_min   = min_reg[idx];
    assign cur_max   = max_reg[idx];
    assign cur_calls = calls_reg[idx];
    assign cur_cnt   = cnt_reg[idx];

    assign elapsed = item_reg.now_time - cur_start;

    assign do_begin = slot_ok && enabled_reg && (item_reg.op == sts_pkg::OP_BEGIN);
    assign do_end   = slot_ok && enabled_reg && (item_reg.op == sts_pkg::OP_END);
    assign do_clear = slot_ok && record_reg && (item_reg.op == sts_pkg::OP_CLEAR);
    assign do_log   = do_end && record_reg && (32'(cur_cnt) < SAMPLES_PER_SLOT);
    assign read_hit = slot_ok && (item_reg.op == sts_pkg::OP_READ)
                      && (32'(item_reg.sample_index) < 32'(cur_cnt))
                      && (32'(item_reg.sample_index) < SAMPLES_PER_SLOT);

    assign cnt_after  = do_log ? (cur_cnt + CW'(1)) : cur_cnt;
    assign start_next = do_begin ? item_reg.now_time : cur_start;
    assign calls_next = do_begin ? (cur_calls + TW'(1)) : cur_calls;
    assign used_next  = cur_used | do_end;
    assign sum_next   = do_end ? (cur_sum + elapsed) : cur_sum;
    assign min_next   = (do_end && (elapsed < cur_min)) ? elapsed : cur_min;
    assign max_next   = (do_end && (elapsed > cur_max)) ? elapsed : cur_max;
    assign cnt_next   = do_clear ? '0 : cnt_after;

    always_comb
    begin
        if (do_clear)
        begin
            peak_next = '0;
        end
        else if (do_end && record_reg && (cnt_after > peak_reg))
        begin
            peak_next = cnt_after;
        end
        else
        begin
            peak_next = peak_reg;
        end
    end

    assign cnt_wide  = {{OW{1'b0}}, cnt_next};
    assign peak_wide = {{OW{1'b0}}, peak_next};

    always_comb
    begin
        out_item_next = '0;
        out_item_next.longest_run = peak_wide[OW-1:0];
        if (slot_ok)
        begin
            out_item_next.slot_used    = used_next;
            out_item_next.elapsed_time = do_end ? elapsed : '0;
            out_item_next.total_time   = sum_next;
            out_item_next.call_count   = calls_next;
            out_item_next.min_time     = min_next;
            out_item_next.max_time     = max_next;
            out_item_next.sample_count = cnt_wide[OW-1:0];
            out_item_next.sample_value = read_hit ? rd_data_reg : '0;
        end
    end

    // sample store addressing
    assign rd_en   = cmd.capture && (in_item.op == sts_pkg::OP_READ)
                     && (32'(in_item.slot) < SLOTS)
                     && (32'(in_item.sample_index) < SAMPLES_PER_SLOT);
    assign rd_addr = AW'(32'(in_item.slot) * SAMPLES_PER_SLOT + 32'(in_item.sample_index));
    assign wr_en   = cmd.commit && do_log;
    assign wr_addr = AW'(32'(item_reg.slot) * SAMPLES_PER_SLOT + 32'(cur_cnt));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= elapsed;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.commit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            record_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sts_pkg::REG_ENABLED: enabled_reg <= cfg_data;
                sts_pkg::REG_RECORD:  record_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                start_reg[i] <= '0;
                used_reg[i]  <= 1'b0;
                sum_reg[i]   <= '0;
                min_reg[i]   <= sts_pkg::TIME_ALL_ONES;
                max_reg[i]   <= '0;
                calls_reg[i] <= '0;
                cnt_reg[i]   <= '0;
            end
            peak_reg <= '0;
        end
        else if (cmd.commit && slot_ok)
        begin
            if (do_clear)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    cnt_reg[i] <= '0;
                end
            end
            start_reg[idx] <= start_next;
            used_reg[idx]  <= used_next;
            sum_reg[idx]   <= sum_next;
            min_reg[idx]   <= min_next;
            max_reg[idx]   <= max_next;
            calls_reg[idx] <= calls_next;
            cnt_reg[idx]   <= cnt_next;
            peak_reg       <= peak_next;
        end
    end

    assign out_item = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/section_timing_statistics_unit.sv =====
// Top level of the section timing statistics unit.
//
// Per-slot timing monitor. Each input item carries an op (begin, end, query,
// read sample, clear samples), a slot, a timestamp and a sample index; every
// item returns exactly one result item with the slot's statistics after the op.
// Input and output channels use valid/stall; the config channel uses
// valid/ready (always ready) and writes enabled (index 0) or record_samples
// (index 1). Write config only while no item is in flight.
// The input item is registered on accept; the result item is registered into the output
// register when the execute state commits. No new item is taken before that commit,
// as set by the single read-modify-write of the slot record and the one-port sample store
// (read issued on accept, write on execute).
// Reset: all slot statistics clear, min goes to all ones, enabled is set and
// recording is off. The sample store is not cleared; only logged entries are
// ever returned.
// Output stall: the result holds in the output register; the next item is
// still accepted and waits in execute until the result is taken.
`default_nettype none

module section_timing_statistics_unit #(
    parameter int SLOTS            = 32,
    parameter int SAMPLES_PER_SLOT = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire sts_pkg::in_item_t               in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output sts_pkg::out_item_t                   out_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic                            cfg_data
);

    sts_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    sts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sts_datapath #(
        .SLOTS            (SLOTS),
        .SAMPLES_PER_SLOT (SAMPLES_PER_SLOT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sts_checker.sv =====
// Port-level checker of the section timing statistics unit and its bind.
`default_nettype none
`include "section_timing_statistics_unit_defines.svh"

module sts_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire sts_pkg::out_item_t out_item
);

    `STS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
    `STS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `STS_ASSERT_IMPL(a_min_le_max, clk, rst_n, out_valid && out_item.slot_used, out_item.min_time <= out_item.max_time)
    `STS_ASSERT_IMPL(a_unused_empty, clk, rst_n, out_valid && !out_item.slot_used, out_item.total_time == 0 && out_item.max_time == 0 && out_item.elapsed_time == 0)

endmodule

bind section_timing_statistics_unit sts_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire

// ===== tb/sts_result_checker.sv =====
// Checker for the section timing statistics unit: predicts every result item and compares it.
`timescale 1ns / 100ps

module sts_result_checker
    import sts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_item,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_item,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int NSLOT = 32;
    localparam int SPS   = 256;

    logic                en_q;
    logic                rec_q;
    logic [TIME_W-1:0]   start_at    [NSLOT];
    logic                ever_ended  [NSLOT];
    logic [TIME_W-1:0]   time_total  [NSLOT];
    logic [TIME_W-1:0]   time_min    [NSLOT];
    logic [TIME_W-1:0]   time_max    [NSLOT];
    logic [TIME_W-1:0]   begin_calls [NSLOT];
    logic [COUNT_W-1:0]  log_count   [NSLOT];
    logic [TIME_W-1:0]   log_store   [NSLOT*SPS];
    logic [COUNT_W-1:0]  log_peak;

    out_item_t expected_stats [$];
    out_item_t want;

    function automatic out_item_t apply_section_op(in_item_t it);
        out_item_t          res;
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  picked;
        logic [COUNT_W-1:0] cnt;
        int                 s;
        s       = int'(it.slot);
        elapsed = '0;
        picked  = '0;
        case (it.op)
            OP_BEGIN:
                if (en_q)
                begin
                    start_at[s]    = it.now_time;
                    begin_calls[s] = begin_calls[s] + 1'b1;
                end
            OP_END:
                if (en_q)
                begin
                    elapsed       = it.now_time - start_at[s];
                    ever_ended[s] = 1'b1;
                    time_total[s] = time_total[s] + elapsed;
                    if (elapsed < time_min[s])
                        time_min[s] = elapsed;
                    if (elapsed > time_max[s])
                        time_max[s] = elapsed;
                    if (rec_q)
                    begin
                        cnt = log_count[s];
                        if (cnt < SPS)
                        begin
                            log_store[s*SPS + cnt] = elapsed;
                            cnt                    = cnt + 1'b1;
                            log_count[s]           = cnt;
                        end
                        if (cnt > log_peak)
                            log_peak = cnt;
                    end
                end
            OP_READ:
                if (it.sample_index < log_count[s])
                    picked = log_store[s*SPS + it.sample_index];
            OP_CLEAR:
                if (rec_q)
                begin
                    for (int i = 0; i < NSLOT; i++)
                        log_count[i] = '0;
                    log_peak = '0;
                end
            default: ;
        endcase
        res.slot_used    = ever_ended[s];
        res.elapsed_time = elapsed;
        res.total_time   = time_total[s];
        res.call_count   = begin_calls[s];
        res.min_time     = time_min[s];
        res.max_time     = time_max[s];
        res.sample_count = log_count[s];
        res.sample_value = picked;
        res.longest_run  = log_peak;
        return res;
    endfunction

    task automatic check_field(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_q  = 1'b1;
            rec_q = 1'b0;
            for (int i = 0; i < NSLOT; i++)
            begin
                start_at[i]    = '0;
                ever_ended[i]  = 1'b0;
                time_total[i]  = '0;
                time_min[i]    = TIME_ALL_ONES;
                time_max[i]    = '0;
                begin_calls[i] = '0;
                log_count[i]   = '0;
            end
            log_peak = '0;
            expected_stats.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENABLED: en_q  = cfg_data;
                    REG_RECORD:  rec_q = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_stats.pop_front();
                    check_field("slot_used", TIME_W'(want.slot_used),
                                TIME_W'(out_item.slot_used));
                    check_field("elapsed_time", want.elapsed_time, out_item.elapsed_time);
                    check_field("total_time", want.total_time, out_item.total_time);
                    check_field("call_count", want.call_count, out_item.call_count);
                    check_field("min_time", want.min_time, out_item.min_time);
                    check_field("max_time", want.max_time, out_item.max_time);
                    check_field("sample_count", TIME_W'(want.sample_count),
                                TIME_W'(out_item.sample_count));
                    check_field("sample_value", want.sample_value, out_item.sample_value);
                    check_field("longest_run", TIME_W'(want.longest_run),
                                TIME_W'(out_item.longest_run));
                end
            end
            if (in_valid && !in_stall)
                expected_stats.insert(expected_stats.size(), apply_section_op(in_item));
            pending <= expected_stats.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the section timing statistics testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
    import sts_pkg::*;

    localparam int NSLOT = 32;
    localparam int LIMIT = 500000;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ENABLED;
    logic                 cfg_data  = 1'b0;
    int                   fail_count;
    int                   pending;

    int items_sent  = 0;
    bit sender_calm = 1'b0;
    int cycle_count = 0;

    section_timing_statistics_unit dut (.*);

    sts_result_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("section_timing_statistics_unit test failed");
            $finish;
        end
    end

    function automatic in_item_t mk_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                         logic [TIME_W-1:0] t, logic [SIDX_W-1:0] idx);
        in_item_t it;
        it.op           = op;
        it.slot         = slot;
        it.now_time     = t;
        it.sample_index = idx;
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (items_sent % 40 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
        items_sent++;
        gap = sender_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(int n_items, int hot, int pair_pct, bit allow_clear);
        int                done;
        int                s;
        int                r;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] delta;
        logic [OP_W-1:0]   op;
        logic [SIDX_W-1:0] idx;
        done = 0;
        while (done < n_items)
        begin
            s = (hot >= 0 && $urandom_range(0, 99) < 95) ? hot : $urandom_range(0, NSLOT - 1);
            if ($urandom_range(0, 99) < pair_pct)
            begin
                t0 = $urandom;
                r  = $urandom_range(0, 99);
                if (r < 10)
                    delta = '0;
                else if (r < 75)
                    delta = $urandom_range(1, 2000);
                else
                    delta = $urandom;
                send_item(mk_item(OP_BEGIN, SLOT_W'(s), t0, SIDX_W'($urandom)));
                send_item(mk_item(OP_END, SLOT_W'(s), t0 + delta, SIDX_W'($urandom)));
                done += 2;
            end
            else
            begin
                r   = $urandom_range(0, 99);
                idx = SIDX_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                                           : $urandom_range(0, 255));
                if (r < 20)
                    op = OP_QUERY;
                else if (r < 55)
                    op = OP_READ;
                else if (r < 65 && allow_clear)
                    op = OP_CLEAR;
                else if (r < 80)
                    op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                else if (r < 90)
                    op = OP_BEGIN;
                else
                    op = OP_END;
                send_item(mk_item(op, SLOT_W'(s), $urandom, idx));
                done += 1;
            end
        end
    endtask

    // receiver: random stalls per item, two long hold-offs to back up the block
    initial
    begin
        int k;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (taken == 250 || taken == 750)
                k = 160;
            else
                k = calm ? 0 : $urandom_range(0, 14);
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        int hot;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_ENABLED, 1'b1);
        write_reg(REG_RECORD, 1'b1);
        send_item(mk_item(OP_QUERY, 0, '0, '0));
        send_item(mk_item(OP_READ, 0, '0, '0));
        send_item(mk_item(OP_BEGIN, 0, '0, '0));
        send_item(mk_item(OP_END, 0, '0, '0));
        send_item(mk_item(OP_BEGIN, 31, '1, '1));
        send_item(mk_item(OP_END, 31, 32'hFFFF_FFFE, '1));
        send_item(mk_item(OP_BEGIN, 31, 32'hFFFF_FFF0, '0));
        send_item(mk_item(OP_END, 31, 32'd5, '0));
        send_item(mk_item(OP_END, 31, 32'd5, '0));
        send_item(mk_item(OP_READ, 31, '0, 8'd0));
        send_item(mk_item(OP_READ, 31, '0, 8'd2));
        send_item(mk_item(OP_READ, 31, '0, 8'd3));
        send_item(mk_item(OP_READ, 31, '0, '1));
        send_item(mk_item(OP_SPARE_LO, 31, '1, '1));
        send_item(mk_item(OP_SPARE_MID, 0, '0, '0));
        send_item(mk_item(OP_SPARE_HI, 31, '1, '1));

        drain();
        write_reg(REG_ENABLED, 1'b0);
        send_item(mk_item(OP_BEGIN, 1, 32'd100, '0));
        send_item(mk_item(OP_END, 1, 32'd500, '0));
        send_item(mk_item(OP_QUERY, 1, '0, '0));

        drain();
        write_reg(REG_ENABLED, 1'b1);
        write_reg(REG_RECORD, 1'b0);
        send_item(mk_item(OP_END, 31, 32'h40, '0));
        send_item(mk_item(OP_CLEAR, 31, '0, '0));
        send_item(mk_item(OP_READ, 31, '0, 8'd1));

        drain();
        write_reg(REG_RECORD, 1'b1);
        send_item(mk_item(OP_CLEAR, 0, '0, '0));
        send_item(mk_item(OP_READ, 31, '0, 8'd0));
        send_item(mk_item(OP_QUERY, 31, '0, '0));

        run_phase(120, -1, 55, 1'b1);
        drain();
        write_reg(REG_RECORD, 1'b0);
        run_phase(120, -1, 55, 1'b1);
        drain();
        write_reg(REG_ENABLED, 1'b0);
        write_reg(REG_RECORD, 1'b1);
        run_phase(60, -1, 55, 1'b1);
        drain();
        write_reg(REG_RECORD, 1'b0);
        run_phase(40, -1, 55, 1'b1);

        // fill one slot's sample store past its end
        drain();
        write_reg(REG_ENABLED, 1'b1);
        write_reg(REG_RECORD, 1'b1);
        hot = $urandom_range(0, NSLOT - 1);
        run_phase(640, hot, 95, 1'b0);
        send_item(mk_item(OP_READ, SLOT_W'(hot), '0, '1));
        send_item(mk_item(OP_READ, SLOT_W'(hot), '0, '0));
        send_item(mk_item(OP_END, SLOT_W'(hot), $urandom, '0));
        send_item(mk_item(OP_QUERY, SLOT_W'(hot), '0, '0));
        send_item(mk_item(OP_CLEAR, SLOT_W'(hot), '0, '0));
        send_item(mk_item(OP_QUERY, SLOT_W'(hot), '0, '0));
        run_phase(60, -1, 55, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("section_timing_statistics_unit test passed");
        else
            $display("section_timing_statistics_unit test failed");
        $finish;
    end

endmodule
